/* rtl/point_projection_depth_zbuffer_macros.svh */
// Assertion macros shared by the depth map block.
// Both expect clk and rst_n in scope.
`ifndef POINT_PROJECTION_DEPTH_ZBUFFER_MACROS_SVH
`define POINT_PROJECTION_DEPTH_ZBUFFER_MACROS_SVH

// Same-cycle implication.
`define PPZ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppz check failed");

// Next-cycle implication.
`define PPZ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppz check failed");

`endif

/* rtl/ppz_pkg.sv */
// ----------------------------------------------------------------------------
// ppz_pkg
// Types, constants and helpers for the point projection depth map block.
// ----------------------------------------------------------------------------
package ppz_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 512;

    // accumulated projection numerator, depth product, divider width
    localparam int NW = 58;
    localparam int PW = 57;
    localparam int DW = 59;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 64;
    localparam int NUM_COEF_REGS = 6;

    localparam logic [CFG_AW-1:0] REG_DEPTH_SCALE = 3'd6;
    localparam logic [CFG_AW-1:0] REG_IMAGE_SIZE  = 3'd7;

    localparam logic [31:0] SCALE_RESET = 32'd65536;
    localparam logic [31:0] SIZE_RESET  = 32'h0200_0400;

    // depth = (|z*scale| + 32768000) / (1000 * 2^16); saturates at 1000 * 2^32
    localparam logic [NW-1:0] DEPTH_HALF  = NW'(32768000);
    localparam logic [NW-1:0] DEPTH_SAT   = NW'(64'd4294967296000);
    // ceil(2^36 / 1000): exact floor(n / 1000) for n below 2^26
    localparam logic [26:0]   DEPTH_RECIP = 27'd68719477;
    localparam logic [15:0]   DEPTH_MAX   = 16'hFFFF;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_PROJECT = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    typedef logic [NUM_COEF_REGS-1:0][63:0] coef_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [23:0] point_x_mm;
        logic signed [23:0] point_y_mm;
        logic signed [23:0] point_z_mm;
        logic [9:0]         read_col;
        logic [8:0]         read_row;
    } point_t;

    typedef struct packed {
        logic        inside_res;
        logic [9:0]  pixel_col;
        logic [8:0]  pixel_row;
        logic [15:0] stored_depth;
        logic        updated;
    } result_t;

    typedef struct packed {
        logic signed [NW-1:0] n0;
        logic signed [NW-1:0] n1;
        logic signed [NW-1:0] n2;
        logic signed [PW-1:0] dprod;
    } proj_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_RD,
        ST_DONE
    } state_e;

    function automatic logic [NW-1:0] mag_n(input logic signed [NW-1:0] v);
        mag_n = v[NW-1] ? NW'(-v) : NW'(v);
    endfunction

endpackage

/* rtl/ppz_mem.sv */
// ----------------------------------------------------------------------------
// ppz_mem
// Depth store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppz_mem #(
    parameter int DEPTH = 524288,
    parameter int AW    = 19
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ppz_div.sv */
// ----------------------------------------------------------------------------
// ppz_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppz_div #(
    parameter int W = 59
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo,
    output logic         done
);

    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;
    logic [W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

/* rtl/ppz_mac.sv */
// ----------------------------------------------------------------------------
// ppz_mac
// Projection sequencer: one shared 33x24 multiplier, nine coefficient
// products accumulated into three row numerators, then the depth product.
// ----------------------------------------------------------------------------
module ppz_mac (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [23:0]    x,
    input  logic signed [23:0]    y,
    input  logic signed [23:0]    z,
    input  ppz_pkg::coef_t        coefs,
    input  logic [31:0]           scale,
    output ppz_pkg::proj_t        res,
    output logic                  done
);

    localparam int NW = ppz_pkg::NW;
    localparam int PW = ppz_pkg::PW;
    localparam logic [3:0] LAST_STEP = 4'd9;

    logic                 busy_reg;
    logic [3:0]           step_reg;
    logic                 pv_reg;
    logic [3:0]           pstep_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [NW-1:0] acc0_reg;
    logic signed [NW-1:0] acc1_reg;
    logic signed [NW-1:0] acc2_reg;
    logic signed [PW-1:0] dprod_reg;
    logic                 done_reg;

    logic signed [32:0]   op_a;
    logic signed [23:0]   op_b;
    logic signed [PW-1:0] mul;
    logic signed [NW-1:0] t0;
    logic signed [NW-1:0] t1;
    logic signed [NW-1:0] t2;

    // 1000 * c = 1024c - 16c - 8c
    function automatic logic signed [NW-1:0] times1000(input logic [31:0] c);
        logic signed [NW-1:0] e;
        e = NW'(signed'(c));
        times1000 = (e <<< 10) - (e <<< 4) - (e <<< 3);
    endfunction

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            4'd0:    begin op_a = {coefs[0][31], coefs[0][31:0]};   op_b = x; end
            4'd1:    begin op_a = {coefs[0][63], coefs[0][63:32]};  op_b = y; end
            4'd2:    begin op_a = {coefs[1][31], coefs[1][31:0]};   op_b = z; end
            4'd3:    begin op_a = {coefs[2][31], coefs[2][31:0]};   op_b = x; end
            4'd4:    begin op_a = {coefs[2][63], coefs[2][63:32]};  op_b = y; end
            4'd5:    begin op_a = {coefs[3][31], coefs[3][31:0]};   op_b = z; end
            4'd6:    begin op_a = {coefs[4][31], coefs[4][31:0]};   op_b = x; end
            4'd7:    begin op_a = {coefs[4][63], coefs[4][63:32]};  op_b = y; end
            4'd8:    begin op_a = {coefs[5][31], coefs[5][31:0]};   op_b = z; end
            4'd9:    begin op_a = {1'b0, scale};                    op_b = z; end
            default: begin op_a = '0;                               op_b = '0; end
        endcase
        mul = PW'(op_a) * PW'(op_b);
    end

    always_comb
    begin
        t0 = times1000(coefs[1][63:32]);
        t1 = times1000(coefs[3][63:32]);
        t2 = times1000(coefs[5][63:32]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            pv_reg    <= 1'b0;
            pstep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg  <= 1'b0;
            pv_reg    <= busy_reg;
            pstep_reg <= step_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (pv_reg && pstep_reg == LAST_STEP)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul;
        if (start)
        begin
            acc0_reg <= t0;
            acc1_reg <= t1;
            acc2_reg <= t2;
        end
        else if (pv_reg)
        begin
            case (pstep_reg) inside
                4'd0, 4'd1, 4'd2: acc0_reg <= acc0_reg + NW'(prod_reg);
                4'd3, 4'd4, 4'd5: acc1_reg <= acc1_reg + NW'(prod_reg);
                4'd6, 4'd7, 4'd8: acc2_reg <= acc2_reg + NW'(prod_reg);
                default:          dprod_reg <= prod_reg;
            endcase
        end
    end

    assign res.n0    = acc0_reg;
    assign res.n1    = acc1_reg;
    assign res.n2    = acc2_reg;
    assign res.dprod = dprod_reg;
    assign done      = done_reg;

endmodule

/* rtl/point_projection_depth_zbuffer.sv */
// ----------------------------------------------------------------------------
// point_projection_depth_zbuffer
// Projects lidar points through a 3x4 matrix into a z-buffered 16-bit depth
// map held in on-chip memory; also clears the map and reads single pixels.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  point     in         point_valid / point_stall  ppz_pkg::point_t
//  result    out        result_valid / result_stall ppz_pkg::result_t
//  cfg       in         cfg_wr_en                  cfg_index, cfg_data
//
//  Project: the shared multiplier, then the 59-step column and row dividers
//  running side by side, then the pixel read-modify-write and the result
//  register. Depth comes from a reciprocal multiply while the dividers run.
//  Read: the memory read, then the result register.
//  Clear: one entry per cycle, MAX_WIDTH*MAX_HEIGHT entries; the same sweep
//  runs after reset, with point_stall high throughout.
//  One transaction is in work at a time; a result waiting on result_stall
//  does not block the next point until that point finishes.
// ----------------------------------------------------------------------------
`include "point_projection_depth_zbuffer_macros.svh"

module point_projection_depth_zbuffer #(
    parameter int MAX_WIDTH  = ppz_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ppz_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          point_valid,
    output logic                          point_stall,
    input  ppz_pkg::point_t               point_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ppz_pkg::result_t              result_data,
    input  logic                          cfg_wr_en,
    input  logic [ppz_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [ppz_pkg::CFG_DW-1:0]    cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int NW    = ppz_pkg::NW;
    localparam int DW    = ppz_pkg::DW;

    ppz_pkg::state_e   state_reg, state_next;
    ppz_pkg::point_t   item_reg, item_next;
    ppz_pkg::result_t  pend_reg, pend_next;
    ppz_pkg::result_t  out_reg;
    logic              out_valid_reg;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clr_res_reg, clr_res_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [15:0]       depth_reg, depth_next;
    logic              dpos_reg, dpos_next;
    logic              out_load;

    ppz_pkg::coef_t    coef_reg;
    logic [31:0]       scale_reg;
    logic [31:0]       size_reg;

    logic              mac_start, mac_done;
    ppz_pkg::proj_t    proj;
    logic              div_start;
    logic              done_c, done_r;
    logic [DW-1:0]     q_col, q_row;
    logic [DW-1:0]     b2, num_c, num_r, den_2b;

    logic [NW-1:0]     dep_num_reg, dep_num_next;
    logic [25:0]       dep_hi;
    logic [52:0]       dep_prod;
    logic [15:0]       dval_reg, dval_next;
    logic              dnz_reg, dnz_next;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata, mem_rdata;

    logic [15:0]       w_lim, h_lim;
    logic              ncol, nrow, in_bounds;
    logic [AW-1:0]     proj_addr, rd_addr;
    logic              rd_in_range;
    logic              dpos;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg  <= '0;
            scale_reg <= ppz_pkg::SCALE_RESET;
            size_reg  <= ppz_pkg::SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ppz_pkg::REG_DEPTH_SCALE: scale_reg <= cfg_data[31:0];
                ppz_pkg::REG_IMAGE_SIZE:  size_reg  <= cfg_data[31:0];
                default:                  coef_reg[cfg_index] <= cfg_data;
            endcase
        end
    end

    ppz_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .x     (item_reg.point_x_mm),
        .y     (item_reg.point_y_mm),
        .z     (item_reg.point_z_mm),
        .coefs (coef_reg),
        .scale (scale_reg),
        .res   (proj),
        .done  (mac_done)
    );

    // round half away from zero: (2|n| + |d|) / (2|d|)
    always_comb
    begin
        b2     = DW'(ppz_pkg::mag_n(proj.n2));
        den_2b = b2 << 1;
        num_c  = (DW'(ppz_pkg::mag_n(proj.n0)) << 1) + b2;
        num_r  = (DW'(ppz_pkg::mag_n(proj.n1)) << 1) + b2;
    end

    // Depth is registered in dep_num_reg, then dval_reg, while the dividers run:
    // dividing by 1000 * 2^16 is a shift by 16 and a reciprocal multiply for the 1000.
    always_comb
    begin
        dep_num_next = ppz_pkg::mag_n(NW'(proj.dprod)) + ppz_pkg::DEPTH_HALF;
        dep_hi       = dep_num_reg[41:16];
        dep_prod     = 53'(dep_hi) * 53'(ppz_pkg::DEPTH_RECIP);
        if (dep_num_reg >= ppz_pkg::DEPTH_SAT)
        begin
            dval_next = ppz_pkg::DEPTH_MAX;
            dnz_next  = 1'b1;
        end
        else
        begin
            dval_next = dep_prod[51:36];
            dnz_next  = (dep_prod[51:36] != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        dep_num_reg <= dep_num_next;
        dval_reg    <= dval_next;
        dnz_reg     <= dnz_next;
    end

    ppz_div #(.W(DW)) u_div_col (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .num (num_c), .den (den_2b), .quo (q_col), .done (done_c)
    );

    ppz_div #(.W(DW)) u_div_row (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .num (num_r), .den (den_2b), .quo (q_row), .done (done_r)
    );

    ppz_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // bounds, address and depth of the projected point
    always_comb
    begin
        w_lim = (size_reg[15:0] > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : size_reg[15:0];
        h_lim = (size_reg[31:16] > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : size_reg[31:16];
        ncol  = (proj.n0[NW-1] != proj.n2[NW-1]) && (q_col != '0);
        nrow  = (proj.n1[NW-1] != proj.n2[NW-1]) && (q_row != '0);
        in_bounds = !ncol && !nrow && (q_col < DW'(w_lim)) && (q_row < DW'(h_lim));
        proj_addr = AW'(q_row[RW-1:0]) * AW'(MAX_WIDTH) + AW'(q_col[CW-1:0]);
        dpos  = !proj.dprod[ppz_pkg::PW-1] && (proj.dprod != '0) && dnz_reg;
        rd_in_range = (13'(point_data.read_col) < 13'(MAX_WIDTH))
                   && (13'(point_data.read_row) < 13'(MAX_HEIGHT));
        rd_addr = AW'(point_data.read_row) * AW'(MAX_WIDTH) + AW'(point_data.read_col);
    end

    // Items run one at a time and the write lands in the read's next cycle,
    // so a read never meets an in-flight write to the same pixel.
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        pend_next     = pend_reg;
        clr_addr_next = clr_addr_reg;
        clr_res_next  = clr_res_reg;
        addr_next     = addr_reg;
        depth_next    = depth_reg;
        dpos_next     = dpos_reg;
        mac_start     = 1'b0;
        div_start     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = rd_addr;
        out_load      = 1'b0;

        unique case (state_reg)
            ppz_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_addr_next = '0;
                    clr_res_next  = 1'b0;
                    pend_next     = '0;
                    state_next    = clr_res_reg ? ppz_pkg::ST_DONE : ppz_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ppz_pkg::ST_IDLE:
            begin
                if (point_valid)
                begin
                    item_next = point_data;
                    pend_next = '0;
                    case (point_data.cmd)
                        ppz_pkg::CMD_CLEAR:
                        begin
                            clr_res_next = 1'b1;
                            state_next   = ppz_pkg::ST_CLEAR;
                        end
                        ppz_pkg::CMD_PROJECT:
                        begin
                            mac_start  = 1'b1;
                            state_next = ppz_pkg::ST_MAC;
                        end
                        ppz_pkg::CMD_READ:
                        begin
                            pend_next.pixel_col = point_data.read_col;
                            pend_next.pixel_row = point_data.read_row;
                            if (rd_in_range)
                            begin
                                mem_re     = 1'b1;
                                state_next = ppz_pkg::ST_RD;
                            end
                            else
                            begin
                                state_next = ppz_pkg::ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ppz_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ppz_pkg::ST_MAC:
            begin
                if (mac_done)
                begin
                    if (proj.n2 == '0)
                    begin
                        state_next = ppz_pkg::ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ppz_pkg::ST_DIV;
                    end
                end
            end
            ppz_pkg::ST_DIV:
            begin
                if (done_c)
                begin
                    if (in_bounds)
                    begin
                        pend_next.inside_res = 1'b1;
                        pend_next.pixel_col  = q_col[9:0];
                        pend_next.pixel_row  = q_row[8:0];
                        addr_next  = proj_addr;
                        depth_next = dval_reg;
                        dpos_next  = dpos;
                        mem_re     = 1'b1;
                        mem_raddr  = proj_addr;
                        state_next = ppz_pkg::ST_RD;
                    end
                    else
                    begin
                        state_next = ppz_pkg::ST_DONE;
                    end
                end
            end
            ppz_pkg::ST_RD:
            begin
                pend_next.stored_depth = mem_rdata;
                if (item_reg.cmd == ppz_pkg::CMD_PROJECT && dpos_reg
                    && (mem_rdata == '0 || mem_rdata > depth_reg))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_reg;
                    mem_wdata = depth_reg;
                    pend_next.stored_depth = depth_reg;
                    pend_next.updated      = 1'b1;
                end
                state_next = ppz_pkg::ST_DONE;
            end
            ppz_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ppz_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppz_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppz_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_res_reg  <= clr_res_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        pend_reg  <= pend_next;
        addr_reg  <= addr_next;
        depth_reg <= depth_next;
        dpos_reg  <= dpos_next;
        if (out_load)
        begin
            out_reg <= pend_reg;
        end
    end

    assign point_stall  = (state_reg != ppz_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    `PPZ_ASSERT_NEXT(a_one_in_work, point_valid && !point_stall, point_stall)
    `PPZ_ASSERT_NOW(a_div_lockstep, done_c, done_r)
    `PPZ_ASSERT_NOW(a_depth_nonzero, mem_we && state_reg == ppz_pkg::ST_RD, mem_wdata != '0)

endmodule

/* tb/point_projection_depth_zbuffer_test.sv */
// ----------------------------------------------------------------------------
// point_projection_depth_zbuffer_test
// Drives clear, project and read transactions into the depth map block. A
// local model of the projection, the rounding and the z-buffer store predicts
// each result, which is compared field by field as it leaves the block. The
// run walks several projection setups with random idling on both channels.
// ----------------------------------------------------------------------------
module point_projection_depth_zbuffer_test;

    localparam logic [ppz_pkg::CFG_AW-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [ppz_pkg::CFG_AW-1:0] REG_ROW0_C23 = 3'd1;
    localparam logic [ppz_pkg::CFG_AW-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [ppz_pkg::CFG_AW-1:0] REG_ROW1_C23 = 3'd3;
    localparam logic [ppz_pkg::CFG_AW-1:0] REG_ROW2_C01 = 3'd4;
    localparam logic [ppz_pkg::CFG_AW-1:0] REG_ROW2_C23 = 3'd5;
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int FOCAL = 500;

    logic clk;
    logic rst_n;
    logic point_valid;
    logic point_stall;
    ppz_pkg::point_t point_data;
    logic result_valid;
    logic result_stall;
    ppz_pkg::result_t result_data;
    logic cfg_wr_en;
    logic [ppz_pkg::CFG_AW-1:0] cfg_index;
    logic [ppz_pkg::CFG_DW-1:0] cfg_data;

    ppz_pkg::point_t point_queue[$];
    ppz_pkg::result_t awaited_results[$];
    logic [15:0] depth_map[int];
    logic [63:0] proj_regs[8];
    int sender_idle_pct;
    int recv_stall_pct;
    logic hold_off;
    int err_cnt;
    int center_col;
    int center_row;

    point_projection_depth_zbuffer uut (
        .clk(clk),
        .rst_n(rst_n),
        .point_valid(point_valid),
        .point_stall(point_stall),
        .point_data(point_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint coef(int r, int k);
        logic [63:0] w;
        w = proj_regs[r * 2 + k / 2];
        return longint'(signed'(k % 2 ? w[63:32] : w[31:0]));
    endfunction

    // round n/d half away from zero
    function automatic void round_div(input longint n, input longint d,
                                      output longint unsigned q, output bit neg);
        longint unsigned a;
        longint unsigned b;
        a = n < 0 ? longint'(-n) : n;
        b = d < 0 ? longint'(-d) : d;
        q = (2 * a + b) / (2 * b);
        neg = ((n < 0) != (d < 0)) && q != 0;
    endfunction

    function automatic ppz_pkg::result_t project_point(ppz_pkg::point_t p);
        ppz_pkg::result_t res;
        longint nrm[3];
        longint pos[3];
        longint unsigned col, row, w, h, q, pm;
        longint prod;
        bit ncol, nrow;
        int idx;
        res = '0;
        case (p.cmd)
            ppz_pkg::CMD_CLEAR: depth_map.delete();
            ppz_pkg::CMD_READ:
            begin
                res.pixel_col = p.read_col;
                res.pixel_row = p.read_row;
                idx = int'(p.read_row) * ppz_pkg::MAX_WIDTH_DEF + int'(p.read_col);
                if (depth_map.exists(idx))
                    res.stored_depth = depth_map[idx];
            end
            ppz_pkg::CMD_PROJECT:
            begin
                pos[0] = p.point_x_mm;
                pos[1] = p.point_y_mm;
                pos[2] = p.point_z_mm;
                for (int r = 0; r < 3; r++)
                    nrm[r] = coef(r, 0) * pos[0] + coef(r, 1) * pos[1]
                           + coef(r, 2) * pos[2] + coef(r, 3) * 1000;
                w = proj_regs[ppz_pkg::REG_IMAGE_SIZE][15:0];
                h = proj_regs[ppz_pkg::REG_IMAGE_SIZE][31:16];
                if (w > ppz_pkg::MAX_WIDTH_DEF) w = ppz_pkg::MAX_WIDTH_DEF;
                if (h > ppz_pkg::MAX_HEIGHT_DEF) h = ppz_pkg::MAX_HEIGHT_DEF;
                if (nrm[2] != 0)
                begin
                    round_div(nrm[0], nrm[2], col, ncol);
                    round_div(nrm[1], nrm[2], row, nrow);
                    if (!ncol && !nrow && col < w && row < h)
                    begin
                        idx = int'(row) * ppz_pkg::MAX_WIDTH_DEF + int'(col);
                        if (!depth_map.exists(idx)) depth_map[idx] = 16'd0;
                        prod = pos[2]
                             * longint'(proj_regs[ppz_pkg::REG_DEPTH_SCALE][31:0]);
                        pm = prod < 0 ? longint'(-prod) : prod;
                        q = (pm + 32768000) / 65536000;
                        if (prod > 0 && q > 0)
                        begin
                            if (q > 65535) q = 65535;
                            if (depth_map[idx] == 0 || depth_map[idx] > q)
                            begin
                                depth_map[idx] = q[15:0];
                                res.updated = 1'b1;
                            end
                        end
                        res.inside_res = 1'b1;
                        res.pixel_col = col[9:0];
                        res.pixel_row = row[8:0];
                        res.stored_depth = depth_map[idx];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report(string field, longint unsigned exp_v, longint unsigned got_v);
        $display("mismatch on %s: expected %0d, got %0d", field, exp_v, got_v);
        err_cnt++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid <= 1'b0;
            point_data <= '0;
        end
        else
        begin
            if (point_valid && !point_stall)
                awaited_results.push_back(project_point(point_data));
            if (!point_valid || !point_stall)
            begin
                if (point_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    point_data <= point_queue.pop_front();
                    point_valid <= 1'b1;
                end
                else
                begin
                    point_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        ppz_pkg::result_t e;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("result with no transaction pending");
                    err_cnt++;
                end
                else
                begin
                    e = awaited_results.pop_front();
                    if (e.inside_res != result_data.inside_res)
                        report("inside_res", e.inside_res, result_data.inside_res);
                    if (e.pixel_col != result_data.pixel_col)
                        report("pixel_col", e.pixel_col, result_data.pixel_col);
                    if (e.pixel_row != result_data.pixel_row)
                        report("pixel_row", e.pixel_row, result_data.pixel_row);
                    if (e.stored_depth != result_data.stored_depth)
                        report("stored_depth", e.stored_depth, result_data.stored_depth);
                    if (e.updated != result_data.updated)
                        report("updated", e.updated, result_data.updated);
                end
            end
            result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic cfg_write(logic [ppz_pkg::CFG_AW-1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        proj_regs[idx] = idx >= ppz_pkg::REG_DEPTH_SCALE ? {32'd0, val[31:0]} : val;
    endtask

    task automatic set_pinhole(int ccol, int crow, int t0, int t1);
        center_col = ccol;
        center_row = crow;
        cfg_write(REG_ROW0_C01, {32'd0, 32'(FOCAL << 16)});
        cfg_write(REG_ROW0_C23, {32'(t0), 32'(ccol << 16)});
        cfg_write(REG_ROW1_C01, {32'(-(FOCAL << 16)), 32'd0});
        cfg_write(REG_ROW1_C23, {32'(t1), 32'(crow << 16)});
        cfg_write(REG_ROW2_C01, 64'd0);
        cfg_write(REG_ROW2_C23, {32'd0, 32'd65536});
    endtask

    function automatic ppz_pkg::point_t mk(logic [1:0] c, int x, int y, int z,
                                           int col, int row);
        ppz_pkg::point_t p;
        p.cmd = c;
        p.point_x_mm = 24'(x);
        p.point_y_mm = 24'(y);
        p.point_z_mm = 24'(z);
        p.read_col = 10'(col);
        p.read_row = 9'(row);
        return p;
    endfunction

    function automatic ppz_pkg::point_t random_point();
        int sel, z, dc, dr;
        sel = $urandom_range(99);
        z = $urandom_range(500, 60000);
        if (sel < 60)
            return mk(ppz_pkg::CMD_PROJECT, $urandom_range(0, 2 * z) - z,
                      ($urandom_range(0, z) - z / 2), z, $urandom, $urandom);
        if (sel < 75)
        begin
            // a handful of pixels hit over and over: exercises the z test
            dc = $urandom_range(0, 6) - 3;
            dr = $urandom_range(0, 6) - 3;
            return mk(ppz_pkg::CMD_PROJECT, z * dc / FOCAL, -z * dr / FOCAL, z, 0, 0);
        end
        if (sel < 85)
            return mk(ppz_pkg::CMD_READ, $urandom, $urandom, $urandom,
                      center_col + $urandom_range(0, 6) - 3,
                      center_row + $urandom_range(0, 6) - 3);
        if (sel < 90)
            return mk(ppz_pkg::CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
        return mk(2'($urandom_range(1, 3)), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    endfunction

    // sampled at the falling edge so the driver's updates have settled
    task automatic drain();
        while (point_queue.size() > 0 || point_valid || awaited_results.size() > 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic run_random(int n, int idle, int stall);
        sender_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) point_queue.push_back(random_point());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_off = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        err_cnt = 0;
        foreach (proj_regs[i]) proj_regs[i] = 64'd0;
        proj_regs[ppz_pkg::REG_DEPTH_SCALE] = ppz_pkg::SCALE_RESET;
        proj_regs[ppz_pkg::REG_IMAGE_SIZE] = ppz_pkg::SIZE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_pinhole(512, 256, 0, 0);
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 0, 0, 5000, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 0, 0, 8000, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 0, 0, 3000, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 0, 0, 1499, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 0, 0, 400, 0, 0));     // zero depth
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 7, 9, 0, 0, 0));       // zero denominator
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 0, 0, -5000, 0, 0));   // negative denominator
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 8388607, -8388608, 8388607, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, -8388608, 8388607, -8388608, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 8388607, 0, 1, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, -1024, 512, 1000, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 1022, -510, 1000, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_PROJECT, 1024, 0, 1000, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_READ, 0, 0, 0, 512, 256));
        point_queue.push_back(mk(ppz_pkg::CMD_READ, 0, 0, 0, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_READ, 0, 0, 0, 1023, 511));
        point_queue.push_back(mk(CMD_NOP, -1, -1, -1, 1023, 511));
        point_queue.push_back(mk(ppz_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
        point_queue.push_back(mk(ppz_pkg::CMD_READ, 0, 0, 0, 512, 256));
        point_queue.push_back(mk(ppz_pkg::CMD_READ, 0, 0, 0, 1023, 511));
        drain();

        cfg_write(ppz_pkg::REG_DEPTH_SCALE, 64'd6553600);
        cfg_write(ppz_pkg::REG_IMAGE_SIZE, {32'd0, 16'd480, 16'd640});
        set_pinhole(320, 240, 0, 0);
        run_random(400, 0, 0);
        run_random(400, 62, 0);

        // long receiver hold-off while points keep coming
        recv_stall_pct = 62;
        hold_off <= 1'b1;
        repeat (300) point_queue.push_back(random_point());
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
        run_random(100, 0, 62);

        cfg_write(ppz_pkg::REG_DEPTH_SCALE, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(ppz_pkg::REG_IMAGE_SIZE, 64'hFFFF_FFFF);
        for (int i = 0; i < 6; i++)
            cfg_write(i[ppz_pkg::CFG_AW-1:0], {$urandom, $urandom});
        run_random(100, 7, 7);
        set_pinhole(512, 256, 40 << 16, -(25 << 16));
        run_random(150, 7, 7);

        cfg_write(ppz_pkg::REG_DEPTH_SCALE, 64'd0);
        cfg_write(ppz_pkg::REG_IMAGE_SIZE, {32'd0, 16'd255, 16'd256});
        set_pinhole(128, 100, 0, 0);
        run_random(100, 62, 62);
        cfg_write(ppz_pkg::REG_DEPTH_SCALE, 64'd1);
        run_random(100, 0, 0);

        repeat (200) @(posedge clk);
        if (err_cnt == 0 && awaited_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
